FILE: sv/jlcg_pkg.sv
// Shared types and constants for the 48-bit LCG random number block.
package jlcg_pkg;

  localparam logic [47:0] LcgMult = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LcgInc  = 48'h0000_0000_000B;

  typedef enum logic [1:0] {
    CMD_SEED    = 2'd0,
    CMD_BITS    = 2'd1,
    CMD_BOUNDED = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RES_KEEP,
    RES_ZERO,
    RES_BITS,
    RES_POW,
    RES_REM
  } res_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADV_MUL,
    ST_ADV_SUM,
    ST_BITS,
    ST_POW,
    ST_DIV,
    ST_CHECK
  } state_e;

  typedef struct packed {
    logic     latch;
    logic     load_seed;
    logic     mul_load;
    logic     state_load;
    logic     div_step;
    res_sel_e res_sel;
    logic     out_load;
  } dp_ctrl_t;

  typedef struct packed {
    cmd_e cmd;
    logic bound_small;
    logic bound_pow2;
    logic div_last;
    logic draw_ok;
  } dp_status_t;

endpackage

FILE: sv/jlcg_ctrl.sv
// Controller state machine that sequences seeding, state advance, division and output.
module jlcg_ctrl import jlcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_ctrl_t   ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   done;
  logic   out_pending_q;
  logic   out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.res_sel  = RES_KEEP;
    ctrl_o.out_load = out_load;
    done            = 1'b0;
    in_stall_o      = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = out_pending_q;
        if (in_valid_i && !out_pending_q) begin
          ctrl_o.latch = 1'b1;
          state_d      = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status_i.cmd)
          CMD_SEED: begin
            ctrl_o.load_seed = 1'b1;
            ctrl_o.res_sel   = RES_ZERO;
            done             = 1'b1;
          end
          CMD_BITS: state_d = ST_ADV_MUL;
          CMD_BOUNDED: begin
            if (status_i.bound_small) begin
              ctrl_o.res_sel = RES_ZERO;
              done           = 1'b1;
            end else begin
              state_d = ST_ADV_MUL;
            end
          end
          default: begin
            ctrl_o.res_sel = RES_ZERO;
            done           = 1'b1;
          end
        endcase
      end
      ST_ADV_MUL: begin
        ctrl_o.mul_load = 1'b1;
        state_d         = ST_ADV_SUM;
      end
      ST_ADV_SUM: begin
        ctrl_o.state_load = 1'b1;
        priority if (status_i.cmd == CMD_BITS) begin
          state_d = ST_BITS;
        end else if (status_i.bound_pow2) begin
          state_d = ST_POW;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_BITS: begin
        ctrl_o.res_sel = RES_BITS;
        done           = 1'b1;
      end
      ST_POW: begin
        ctrl_o.res_sel = RES_POW;
        done           = 1'b1;
      end
      ST_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // A rejected draw goes around for another state advance.
        if (status_i.draw_ok) begin
          ctrl_o.res_sel = RES_REM;
          done           = 1'b1;
        end else begin
          state_d = ST_ADV_MUL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (done) begin
      state_d = ST_IDLE;
    end
  end

  // The result is marked pending once it is formed and copied to the output register when that is free;
  // the block waits in idle until the output register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_pending_q <= 1'b0;
    end else if (done) begin
      out_pending_q <= 1'b1;
    end else if (out_load) begin
      out_pending_q <= 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_load    = out_pending_q && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_rise_from_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(out_pending_q))
    else $error("output went valid without a pending result");
  a_pending_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_pending_q && state_q != ST_IDLE) |-> 1'b0)
    else $error("result pending while a new item is in work");
  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DECODE))
    else $error("accepted item did not reach decode");
`endif

endmodule

FILE: sv/jlcg_dp.sv
// Datapath: LCG state, split multiplier, restoring remainder unit and result registers.
module jlcg_dp import jlcg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   command_i,
  input  logic [47:0]  seed_value_i,
  input  logic [5:0]   bits_wanted_i,
  input  logic [31:0]  bound_i,
  input  dp_ctrl_t     ctrl_i,
  output dp_status_t   status_o,
  output logic [31:0]  value_o
);

  localparam logic [23:0] MultLo = LcgMult[23:0];
  localparam logic [10:0] MultHi = LcgMult[34:24];

  logic [47:0] lcg_q;
  cmd_e        cmd_q;
  logic [47:0] seed_q;
  logic [5:0]  nbits_q;
  logic [31:0] bound_q;
  logic [47:0] p0_q;
  logic [23:0] p1_q, p2_q;
  logic [30:0] r_q, dvd_q;
  logic [31:0] rem_q;
  logic [4:0]  cnt_q;
  logic [31:0] res_q, value_q;

  // Partial products of state * multiplier, keeping only bits below 2^48.
  logic [47:0] p0_d;
  logic [23:0] p1_d, p2_d;
  logic [47:0] lcg_next;

  assign p0_d = {24'b0, lcg_q[23:0]} * {24'b0, MultLo};
  assign p1_d = lcg_q[23:0] * {13'b0, MultHi};
  assign p2_d = lcg_q[47:24] * MultLo;
  assign lcg_next = p0_q + {p1_q + p2_q, 24'b0} + LcgInc;

  // Top bits of the state, with zero bits giving zero and more than 32 saturating.
  logic [5:0]  n_sat, shamt;
  logic [47:0] shifted;
  logic [31:0] bits_val;

  assign n_sat    = (nbits_q > 6'd32) ? 6'd32 : nbits_q;
  assign shamt    = 6'd48 - n_sat;
  assign shifted  = lcg_q >> shamt;
  assign bits_val = (n_sat == 6'd0) ? 32'd0 : shifted[31:0];

  logic [62:0] pow_prod;
  assign pow_prod = {31'b0, bound_q} * {32'b0, r_q};

  logic [31:0] rem_shift, rem_next;
  assign rem_shift = {rem_q[30:0], dvd_q[30]};
  assign rem_next  = (rem_shift >= bound_q) ? rem_shift - bound_q : rem_shift;

  logic [31:0] chk;
  assign chk = {1'b0, r_q} - rem_q + bound_q - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_q <= '0;
    end else if (ctrl_i.load_seed) begin
      lcg_q <= seed_q ^ LcgMult;
    end else if (ctrl_i.state_load) begin
      lcg_q <= lcg_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q   <= cmd_e'(command_i);
      seed_q  <= seed_value_i;
      nbits_q <= bits_wanted_i;
      bound_q <= bound_i;
    end
    if (ctrl_i.mul_load) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
    if (ctrl_i.state_load) begin
      r_q   <= lcg_next[47:17];
      dvd_q <= lcg_next[47:17];
      rem_q <= '0;
      cnt_q <= 5'd30;
    end else if (ctrl_i.div_step) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[29:0], 1'b0};
      cnt_q <= cnt_q - 5'd1;
    end
    unique case (ctrl_i.res_sel)
      RES_ZERO: res_q <= '0;
      RES_BITS: res_q <= bits_val;
      RES_POW:  res_q <= pow_prod[62:31];
      RES_REM:  res_q <= rem_q;
      default:  res_q <= res_q;
    endcase
    if (ctrl_i.out_load) begin
      value_q <= res_q;
    end
  end

  assign status_o.cmd         = cmd_q;
  assign status_o.bound_small = bound_q[31] || (bound_q <= 32'd1);
  assign status_o.bound_pow2  = (bound_q & (bound_q - 32'd1)) == 32'd0;
  assign status_o.div_last    = (cnt_q == 5'd0);
  assign status_o.draw_ok     = !chk[31];
  assign value_o              = value_q;

`ifndef ASSERT_OFF
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.load_seed || ctrl_i.state_load) |=> $stable(lcg_q))
    else $error("generator state changed without a load");
  a_rem_below_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.div_step |=> (rem_q < bound_q))
    else $error("remainder not below the bound");
  a_bounded_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.res_sel == RES_POW || ctrl_i.res_sel == RES_REM) |=> (res_q < bound_q))
    else $error("bounded result not below the bound");
`endif

endmodule

FILE: sv/java_lcg_bounded_random.sv
// Top level of the 48-bit LCG random number block with seed, bits and bounded commands.
//
//   channel | valid        | stall        | payload
//   input   | in_valid_i   | in_stall_o   | command_i, seed_value_i, bits_wanted_i, bound_i
//   output  | out_valid_o  | out_stall_i  | value_o
//
// One item is in work at a time. Seed, unused commands and bounds of one or less or
// with bit 31 set end in decode. Bits and power-of-two bounds advance the state; other
// bounds also run the one-bit-per-cycle remainder unit, and a rejection repeats both.
// Reset clears the generator state to zero and empties the output register.
// A stalled output holds off new items once the next result is formed and waiting.
module java_lcg_bounded_random import jlcg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   command_i,
  input  logic [47:0]  seed_value_i,
  input  logic [5:0]   bits_wanted_i,
  input  logic [31:0]  bound_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  value_o
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  jlcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  jlcg_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (command_i),
    .seed_value_i  (seed_value_i),
    .bits_wanted_i (bits_wanted_i),
    .bound_i       (bound_i),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .value_o       (value_o)
  );

endmodule
